/* rtl/core/scd_pkg.sv */
package scd_pkg;

    localparam logic [7:0] PREFIX_CODE   = 8'hE0;
    localparam logic [7:0] LSHIFT_MAKE   = 8'h2A;
    localparam logic [7:0] RSHIFT_MAKE   = 8'h36;
    localparam logic [7:0] LSHIFT_BREAK  = 8'hAA;
    localparam logic [7:0] RSHIFT_BREAK  = 8'hB6;
    localparam logic [7:0] NAV_HOME      = 8'h47;
    localparam logic [7:0] NAV_END       = 8'h4F;
    localparam logic [7:0] NAV_PGUP      = 8'h49;
    localparam logic [7:0] NAV_PGDN      = 8'h51;
    localparam logic [7:0] RELEASE_LIMIT = 8'd128;

    localparam logic [7:0] EV_HOME = 8'd0;
    localparam logic [7:0] EV_END  = 8'd1;
    localparam logic [7:0] EV_PGUP = 8'd2;
    localparam logic [7:0] EV_PGDN = 8'd3;

    // decoded result handed from the decoder to the output register
    typedef struct packed {
        logic       valid;
        logic       is_key_event;
        logic [7:0] code;
    } scd_result_t;

    // UK layout, unshifted
    function automatic logic [7:0] rom_plain(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd1:    ch = 8'h1B;
            7'd2:    ch = 8'h31;
            7'd3:    ch = 8'h32;
            7'd4:    ch = 8'h33;
            7'd5:    ch = 8'h34;
            7'd6:    ch = 8'h35;
            7'd7:    ch = 8'h36;
            7'd8:    ch = 8'h37;
            7'd9:    ch = 8'h38;
            7'd10:   ch = 8'h39;
            7'd11:   ch = 8'h30;
            7'd12:   ch = 8'h2D;
            7'd13:   ch = 8'h3D;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h71;
            7'd17:   ch = 8'h77;
            7'd18:   ch = 8'h65;
            7'd19:   ch = 8'h72;
            7'd20:   ch = 8'h74;
            7'd21:   ch = 8'h79;
            7'd22:   ch = 8'h75;
            7'd23:   ch = 8'h69;
            7'd24:   ch = 8'h6F;
            7'd25:   ch = 8'h70;
            7'd26:   ch = 8'h5B;
            7'd27:   ch = 8'h5D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h61;
            7'd31:   ch = 8'h73;
            7'd32:   ch = 8'h64;
            7'd33:   ch = 8'h66;
            7'd34:   ch = 8'h67;
            7'd35:   ch = 8'h68;
            7'd36:   ch = 8'h6A;
            7'd37:   ch = 8'h6B;
            7'd38:   ch = 8'h6C;
            7'd39:   ch = 8'h3B;
            7'd40:   ch = 8'h27;
            7'd41:   ch = 8'h60;
            7'd43:   ch = 8'h23;
            7'd44:   ch = 8'h7A;
            7'd45:   ch = 8'h78;
            7'd46:   ch = 8'h63;
            7'd47:   ch = 8'h76;
            7'd48:   ch = 8'h62;
            7'd49:   ch = 8'h6E;
            7'd50:   ch = 8'h6D;
            7'd51:   ch = 8'h2C;
            7'd52:   ch = 8'h2E;
            7'd53:   ch = 8'h2F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // UK layout, shifted; pound and not signs as Latin-1
    function automatic logic [7:0] rom_shifted(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd1:    ch = 8'h1B;
            7'd2:    ch = 8'h21;
            7'd3:    ch = 8'h22;
            7'd4:    ch = 8'hA3;
            7'd5:    ch = 8'h24;
            7'd6:    ch = 8'h25;
            7'd7:    ch = 8'h5E;
            7'd8:    ch = 8'h26;
            7'd9:    ch = 8'h2A;
            7'd10:   ch = 8'h28;
            7'd11:   ch = 8'h29;
            7'd12:   ch = 8'h5F;
            7'd13:   ch = 8'h2B;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h51;
            7'd17:   ch = 8'h57;
            7'd18:   ch = 8'h45;
            7'd19:   ch = 8'h52;
            7'd20:   ch = 8'h54;
            7'd21:   ch = 8'h59;
            7'd22:   ch = 8'h55;
            7'd23:   ch = 8'h49;
            7'd24:   ch = 8'h4F;
            7'd25:   ch = 8'h50;
            7'd26:   ch = 8'h7B;
            7'd27:   ch = 8'h7D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h41;
            7'd31:   ch = 8'h53;
            7'd32:   ch = 8'h44;
            7'd33:   ch = 8'h46;
            7'd34:   ch = 8'h47;
            7'd35:   ch = 8'h48;
            7'd36:   ch = 8'h4A;
            7'd37:   ch = 8'h4B;
            7'd38:   ch = 8'h4C;
            7'd39:   ch = 8'h3A;
            7'd40:   ch = 8'h40;
            7'd41:   ch = 8'hAC;
            7'd43:   ch = 8'h7E;
            7'd44:   ch = 8'h5A;
            7'd45:   ch = 8'h58;
            7'd46:   ch = 8'h43;
            7'd47:   ch = 8'h56;
            7'd48:   ch = 8'h42;
            7'd49:   ch = 8'h4E;
            7'd50:   ch = 8'h4D;
            7'd51:   ch = 8'h3C;
            7'd52:   ch = 8'h3E;
            7'd53:   ch = 8'h3F;
            7'd57:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/core/scd_in_stage.sv */
module scd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // take a new byte when empty or when the held one moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

/* rtl/core/scd_decode.sv */
module scd_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          scan_byte,
    output scd_pkg::scd_result_t result,
    output logic                shift_held,
    output logic                prefix_seen
);

    logic shift_held_reg;
    logic shift_held_next;
    logic prefix_seen_reg;
    logic prefix_seen_next;

    always_comb
    begin
        shift_held_next     = shift_held_reg;
        prefix_seen_next    = prefix_seen_reg;
        result.valid        = 1'b0;
        result.is_key_event = 1'b0;
        result.code         = 8'h00;

        if (scan_byte == scd_pkg::PREFIX_CODE)
        begin
            prefix_seen_next = 1'b1;
        end
        else if (prefix_seen_reg)
        begin
            // extended code: nav keys only, shift flag left alone
            prefix_seen_next    = 1'b0;
            result.is_key_event = 1'b1;
            result.valid        = 1'b1;
            case (scan_byte)
                scd_pkg::NAV_HOME: result.code = scd_pkg::EV_HOME;
                scd_pkg::NAV_END:  result.code = scd_pkg::EV_END;
                scd_pkg::NAV_PGUP: result.code = scd_pkg::EV_PGUP;
                scd_pkg::NAV_PGDN: result.code = scd_pkg::EV_PGDN;
                default:           result.valid = 1'b0;
            endcase
        end
        else if (scan_byte == scd_pkg::LSHIFT_BREAK || scan_byte == scd_pkg::RSHIFT_BREAK)
        begin
            shift_held_next = 1'b0;
        end
        else if (scan_byte == scd_pkg::LSHIFT_MAKE || scan_byte == scd_pkg::RSHIFT_MAKE)
        begin
            shift_held_next = 1'b1;
        end
        else if (scan_byte < scd_pkg::RELEASE_LIMIT)
        begin
            result.code  = shift_held_reg ? scd_pkg::rom_shifted(scan_byte[6:0])
                                          : scd_pkg::rom_plain(scan_byte[6:0]);
            result.valid = (result.code != 8'h00);
        end

        if (!fire)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_held_reg  <= 1'b0;
            prefix_seen_reg <= 1'b0;
        end
        else if (fire)
        begin
            shift_held_reg  <= shift_held_next;
            prefix_seen_reg <= prefix_seen_next;
        end
    end

    assign shift_held  = shift_held_reg;
    assign prefix_seen = prefix_seen_reg;

endmodule

/* rtl/core/scd_out_reg.sv */
module scd_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  scd_pkg::scd_result_t result,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_code,
    output logic                out_key_event
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] code_reg;
    logic       key_event_reg;

    assign valid_next = load ? result.valid : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg      <= result.code;
            key_event_reg <= result.is_key_event;
        end
    end

    assign out_valid     = valid_reg;
    assign out_code      = code_reg;
    assign out_key_event = key_event_reg;

endmodule

/* rtl/core/scancode_set1_key_decoder_top.sv */
// channel  | group   | tdata                 | tuser
// ---------+---------+-----------------------+-------------------
// input    | s_axis  | [7:0] scan_byte       | -
// output   | m_axis  | [7:0] code            | [0] is_key_event
//
// Two register stages: input register, then decode into the result register.
// The result is registered after the input register; one byte per cycle sustained while m_axis_tready is high.
// Bytes that produce no result (prefix, shift, release, empty ROM slot, non-nav
// extended code) leave the result register empty. rst_n clears both flags and both valid bits.
// A stalled output holds one result and one input byte; s_axis_tready drops only then.
module scancode_set1_key_decoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] scan_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] code
    output logic       m_axis_tuser    // [0] is_key_event
);

    logic                 held_valid;
    logic [7:0]           held_byte;
    logic                 advance;
    logic                 shift_held;
    logic                 prefix_seen;
    scd_pkg::scd_result_t result;

    assign advance = held_valid && (!m_axis_tvalid || m_axis_tready);

    scd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    scd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .scan_byte   (held_byte),
        .result      (result),
        .shift_held  (shift_held),
        .prefix_seen (prefix_seen)
    );

    scd_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_code      (m_axis_tdata),
        .out_key_event (m_axis_tuser)
    );

    // nav events only carry codes 0..3
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:2] == 6'd0)
        else $error("key event code out of range");

    // characters come only from nonzero ROM slots
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != 8'h00)
        else $error("empty character emitted");

    // a held byte is not lost while the output stalls
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !advance |=> held_valid && $stable(held_byte))
        else $error("held input byte overwritten");

    // prefix byte arms the extended flag
    a_prefix_arm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && held_byte == scd_pkg::PREFIX_CODE |=> prefix_seen)
        else $error("prefix not armed");

    // shift is never changed by a byte that follows the prefix
    a_shift_ext: assert property (@(posedge clk) disable iff (!rst_n)
        advance && prefix_seen && held_byte != scd_pkg::PREFIX_CODE
        |=> shift_held == $past(shift_held))
        else $error("shift changed by extended code");

endmodule
